@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL file of the escape-count unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mec_pkg.sv @@
// Types, constants and the saturation helper for the escape-count unit.
package mec_pkg;

    localparam int WORD_W    = 32;            // coordinate word, signed fixed point
    localparam int CNT_W     = 16;            // iteration count width
    localparam int COL_W     = 12;            // width of column and row fields
    localparam int OPA_W     = WORD_W + 1;    // multiplier operand A (holds unsigned index)
    localparam int PROD_W    = OPA_W + WORD_W; // full product width
    localparam int SUM_W     = PROD_W + 1;    // width of sums ahead of saturation
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 24;           // two index fields, whole bytes
    localparam int OUT_DATA_W = 16;

    localparam int INDEX_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 28;

    // Register reset values
    localparam logic signed [WORD_W-1:0] ORIGIN_RE_RST = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] ORIGIN_IM_RST = -32'sd268435456;
    localparam logic signed [WORD_W-1:0] STEP_RE_RST   = 32'sd1048576;
    localparam logic signed [WORD_W-1:0] STEP_IM_RST   = 32'sd1048576;
    localparam logic        [CNT_W-1:0]  MAX_ITER_RST  = 16'd256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_RE = 3'd0,
        CFG_ORIGIN_IM = 3'd1,
        CFG_STEP_RE   = 3'd2,
        CFG_STEP_IM   = 3'd3,
        CFG_MAX_ITER  = 3'd4
    } cfg_reg_t;

    // Clamp a wide signed sum to the signed word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-WORD_W:0] top;
        top = v[SUM_W-1:WORD_W-1];
        if (top == '0 || top == '1) begin
            return v[WORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ rtl/mandelbrot_escape_count_unit.sv @@
// Mandelbrot escape-time counter: one shared multiplier under a small sequencer.
//
// Usage:
//   s_* channel takes one pixel (column, row); m_* channel returns its escape count.
//   cfg_* channel writes origin, step and iteration limit; write it only while idle.
//   The block forms c = origin + index*step, then iterates z = z*z + c from z = c,
//   counting updates while |z|^2 <= 4, capped at max_iterations.
// Timing:
//   One signed 33x32 multiplier is reused for every product. Forming c uses two
//   products (column*step_re, row*step_im); each iteration forms three products
//   (zr*zr, zi*zi, zr*zi) and then one update, and an escape is seen at the zr*zi
//   step. One pixel is in flight at a time: a new pixel is taken only once the
//   sequencer has handed the last count on and returned to idle.
// Stalls and reset:
//   s_tready is high only while the sequencer is idle. A finished count waits in
//   the output register; the next pixel is accepted while it waits, and a second
//   count holds in the sequencer until the output register frees.
//   aresetn (synchronous, active low) empties the block and restores the default
//   view (-2.0, -1.0, step 1/256, limit 256). cfg_ready is always high.
module mandelbrot_escape_count_unit
    import mec_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] column, [23:12] row
    // escape count output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] iteration_count
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

`include "assert_macros.svh"

    localparam int IDX_USE = (INDEX_BITS < COL_W) ? INDEX_BITS : COL_W;
    localparam logic [PROD_W-1:0] LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CR,     // column * step_re
        ST_CI,     // row * step_im, form c real
        ST_CDONE,  // form c imaginary
        ST_SQR,    // zr * zr
        ST_SQI,    // zi * zi
        ST_CROSS,  // zr * zi, escape test
        ST_UPD,    // z update
        ST_DONE    // hand count to output register
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // configuration
    logic signed [WORD_W-1:0] origin_re_reg, origin_im_reg, step_re_reg, step_im_reg;
    logic        [CNT_W-1:0]  max_iter_reg;

    // datapath
    logic        [IDX_USE-1:0] col_reg, row_reg;
    logic signed [WORD_W-1:0]  cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [PROD_W-1:0]  p_reg;
    logic        [PROD_W-2:0]  sr_reg;
    logic signed [PROD_W-2:0]  nr_reg;
    logic        [CNT_W-1:0]   cnt_reg;

    logic signed [OPA_W-1:0]  op_a;
    logic signed [WORD_W-1:0] op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  cr_sum, ci_sum, zr_sum, zi_sum;
    logic        [PROD_W-1:0] mag_sum;
    logic signed [PROD_W-2:0] nr_diff, nr_shift;
    logic signed [PROD_W-1:0] ni_shift;
    logic                     escape;
    logic        [CNT_W-1:0]  cnt_inc;
    logic                     out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_CR: begin
                op_a = OPA_W'(col_reg);
                op_b = step_re_reg;
            end
            ST_CI: begin
                op_a = OPA_W'(row_reg);
                op_b = step_im_reg;
            end
            ST_SQR: begin
                op_a = {zr_reg[WORD_W-1], zr_reg};
                op_b = zr_reg;
            end
            ST_SQI: begin
                op_a = {zi_reg[WORD_W-1], zi_reg};
                op_b = zi_reg;
            end
            ST_CROSS: begin
                op_a = {zr_reg[WORD_W-1], zr_reg};
                op_b = zi_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // Point forming, escape test and update arithmetic
    assign cr_sum   = SUM_W'(origin_re_reg) + SUM_W'(p_reg);
    assign ci_sum   = SUM_W'(origin_im_reg) + SUM_W'(p_reg);
    assign mag_sum  = {1'b0, sr_reg} + {1'b0, p_reg[PROD_W-2:0]};
    assign escape   = (mag_sum > LIMIT);
    assign nr_diff  = signed'(sr_reg - p_reg[PROD_W-2:0]);
    // floor shifts: 2*zr*zi >> F equals zr*zi >> (F-1)
    assign nr_shift = nr_reg >>> FRAC_BITS;
    assign ni_shift = p_reg >>> (FRAC_BITS - 1);
    assign zr_sum   = SUM_W'(nr_shift) + SUM_W'(cr_reg);
    assign zi_sum   = SUM_W'(ni_shift) + SUM_W'(ci_reg);
    assign cnt_inc  = cnt_reg + 1'b1;

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CR;
            ST_CR:    state_next = ST_CI;
            ST_CI:    state_next = ST_CDONE;
            ST_CDONE: state_next = (max_iter_reg == '0) ? ST_DONE : ST_SQR;
            ST_SQR:   state_next = ST_SQI;
            ST_SQI:   state_next = ST_CROSS;
            ST_CROSS: state_next = escape ? ST_DONE : ST_UPD;
            ST_UPD:   state_next = (cnt_inc == max_iter_reg) ? ST_DONE : ST_SQR;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Output valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (state_reg == ST_DONE && out_free) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // State, configuration, datapath and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            origin_re_reg <= ORIGIN_RE_RST;
            origin_im_reg <= ORIGIN_IM_RST;
            step_re_reg   <= STEP_RE_RST;
            step_im_reg   <= STEP_IM_RST;
            max_iter_reg  <= MAX_ITER_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            p_reg        <= prod;

            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_ORIGIN_RE: origin_re_reg <= cfg_data;
                    CFG_ORIGIN_IM: origin_im_reg <= cfg_data;
                    CFG_STEP_RE:   step_re_reg   <= cfg_data;
                    CFG_STEP_IM:   step_im_reg   <= cfg_data;
                    CFG_MAX_ITER:  max_iter_reg  <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    col_reg <= s_tdata[IDX_USE-1:0];
                    row_reg <= s_tdata[COL_W +: IDX_USE];
                    cnt_reg <= '0;
                end
                ST_CI: begin
                    cr_reg <= sat_word(cr_sum);
                    zr_reg <= sat_word(cr_sum);
                end
                ST_CDONE: begin
                    ci_reg <= sat_word(ci_sum);
                    zi_reg <= sat_word(ci_sum);
                end
                ST_SQI: begin
                    sr_reg <= p_reg[PROD_W-2:0];
                end
                ST_CROSS: begin
                    nr_reg <= nr_diff;
                end
                ST_UPD: begin
                    zr_reg  <= sat_word(zr_sum);
                    zi_reg  <= sat_word(zi_sum);
                    cnt_reg <= cnt_inc;
                end
                ST_DONE: begin
                    if (out_free) m_tdata_reg <= cnt_reg;
                end
                default: ;
            endcase
        end
    end

    // Checks
    `ASSERT_IMPL(a_cnt_cap, (state_reg != ST_IDLE), (cnt_reg <= max_iter_reg), "count above limit")
    `ASSERT_NEXT(a_busy_after_accept, (s_tvalid && s_tready), (!s_tready), "ready after accept")
    `ASSERT_IMPL(a_upd_after_test, (state_reg == ST_UPD), ($past(state_reg) == ST_CROSS), "update without escape test")

endmodule
